[hdl/fifo_gang_task_scheduler_core_macros.svh]
// Assertion macros for the gang task scheduler core.
`ifndef FIFO_GANG_TASK_SCHEDULER_CORE_MACROS_SVH
`define FIFO_GANG_TASK_SCHEDULER_CORE_MACROS_SVH

// Invariant, checked on every clock edge outside reset.
`define FGTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define FGTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/fgts_pkg.sv]
// Types, sizes and helpers of the gang task scheduler.
`timescale 1ns / 1ps
package fgts_pkg;

  localparam int NUM_PROCS   = 8;
  localparam int QUEUE_DEPTH = 128;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int PIDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int PCNT_W = $clog2(NUM_PROCS + 1);

  localparam int ID_W     = 10;
  localparam int STEP_W   = 12;
  localparam int PROCS_W  = 4;
  localparam int QCOUNT_W = 8;
  localparam int MASK_W   = 8;
  localparam int FREE_W   = 4;
  localparam int SOLVED_W = 32;

  typedef struct packed {
    logic               task_valid;
    logic [ID_W-1:0]    task_id;
    logic [STEP_W-1:0]  task_steps;
    logic [PROCS_W-1:0] task_procs;
  } task_in_t;

  typedef struct packed {
    logic                assigned;
    logic [ID_W-1:0]     assigned_id;
    logic                requeued;
    logic                dropped;
    logic [QCOUNT_W-1:0] queue_count;
    logic [MASK_W-1:0]   busy_mask;
    logic [MASK_W-1:0]   completed_mask;
    logic [FREE_W-1:0]   free_count;
    logic [SOLVED_W-1:0] total_solved;
  } sched_res_t;

  // one queue entry
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [STEP_W-1:0]  steps;
    logic [PROCS_W-1:0] procs;
  } qentry_t;

  function automatic logic [QPTR_W-1:0] qptr_next(input logic [QPTR_W-1:0] p);
    qptr_next = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

[hdl/fifo_gang_task_scheduler_core.sv]
// Gang task scheduler: task FIFO, processor stepping and gang assignment.
`timescale 1ns / 1ps
`include "fifo_gang_task_scheduler_core_macros.svh"

// One accepted item is one scheduler tick: an optional arriving task is
// appended to the circular queue (dropped when full), every busy processor
// advances one step, then the head task is popped and either started on the
// lowest-indexed free processors or written back at the tail. A single
// step/compare unit visits one processor per cycle, so a tick keeps busy high
// through S_ENQ, the S_STEP sweep, S_POP and S_DONE, with an S_ASSIGN sweep
// before S_DONE when the head task is started (a second processor sweep hands
// out the gang); busy is low in S_IDLE between ticks.
// The result is shown for exactly one cycle with res_valid_o high, on the
// last busy cycle; the receiver cannot stall it. No clearing pass after reset.
module fifo_gang_task_scheduler_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  fgts_pkg::task_in_t    task_i,
  output logic                  res_valid_o,
  output fgts_pkg::sched_res_t  res_o
);
  import fgts_pkg::*;

  localparam int CMP_W  = (PCNT_W > PROCS_W) ? PCNT_W : PROCS_W;
  localparam int FSAT_W = (PCNT_W > FREE_W) ? PCNT_W : FREE_W;
  localparam int MASK_N = (NUM_PROCS < MASK_W) ? NUM_PROCS : MASK_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ENQ    = 6'b000010,
    S_STEP   = 6'b000100,
    S_POP    = 6'b001000,
    S_ASSIGN = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  task_in_t             in_q, in_d;
  logic [QPTR_W-1:0]    head_q, head_d;
  logic [QPTR_W-1:0]    tail_q, tail_d;
  logic [QCNT_W-1:0]    fill_q, fill_d;
  logic [NUM_PROCS-1:0] pbusy_q, pbusy_d;
  logic [STEP_W-1:0]    pstep_q  [NUM_PROCS];
  logic [STEP_W-1:0]    pstep_d  [NUM_PROCS];
  logic [STEP_W-1:0]    ptotal_q [NUM_PROCS];
  logic [STEP_W-1:0]    ptotal_d [NUM_PROCS];
  logic [PIDX_W-1:0]    idx_q, idx_d;
  logic [PCNT_W-1:0]    free_q, free_d;
  logic [PROCS_W-1:0]   left_q, left_d;
  logic [SOLVED_W-1:0]  solved_q, solved_d;
  logic [NUM_PROCS-1:0] comp_q, comp_d;
  logic                 assigned_q, assigned_d;
  logic                 requeued_q, requeued_d;
  logic                 dropped_q, dropped_d;
  logic [ID_W-1:0]      aid_q, aid_d;
  qentry_t              cur_q, cur_d;

  // queue memory
  qentry_t              mem_q [QUEUE_DEPTH];
  qentry_t              rd_q;
  logic                 mem_we;
  qentry_t              mem_wdata;

  logic                 last_proc;

  assign last_proc = (idx_q == PIDX_W'(NUM_PROCS - 1));

  always_comb begin
    logic [STEP_W-1:0] cur_step;
    cur_step   = pstep_q[idx_q];
    state_d    = state_q;
    in_d       = in_q;
    head_d     = head_q;
    tail_d     = tail_q;
    fill_d     = fill_q;
    pbusy_d    = pbusy_q;
    pstep_d    = pstep_q;
    ptotal_d   = ptotal_q;
    idx_d      = idx_q;
    free_d     = free_q;
    left_d     = left_q;
    solved_d   = solved_q;
    comp_d     = comp_q;
    assigned_d = assigned_q;
    requeued_d = requeued_q;
    dropped_d  = dropped_q;
    aid_d      = aid_q;
    cur_d      = cur_q;
    mem_we     = 1'b0;
    mem_wdata  = '{id: in_q.task_id, steps: in_q.task_steps, procs: in_q.task_procs};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          in_d       = task_i;
          comp_d     = '0;
          assigned_d = 1'b0;
          requeued_d = 1'b0;
          dropped_d  = 1'b0;
          aid_d      = '0;
          free_d     = '0;
          idx_d      = '0;
          state_d    = S_ENQ;
        end
      end
      S_ENQ: begin
        if (in_q.task_valid) begin
          if (fill_q == QCNT_W'(QUEUE_DEPTH)) begin
            dropped_d = 1'b1;
          end else begin
            mem_we = 1'b1;
            tail_d = qptr_next(tail_q);
            fill_d = fill_q + 1'b1;
          end
        end
        state_d = S_STEP;
      end
      S_STEP: begin
        // one processor per cycle through the shared step/compare unit
        if (pbusy_q[idx_q]) begin
          if (cur_step < ptotal_q[idx_q]) begin
            cur_step = cur_step + 1'b1;
          end
          pstep_d[idx_q] = cur_step;
          if (cur_step == ptotal_q[idx_q]) begin
            pbusy_d[idx_q]  = 1'b0;
            pstep_d[idx_q]  = '0;
            ptotal_d[idx_q] = '0;
            comp_d[idx_q]   = 1'b1;
            free_d          = free_q + 1'b1;
            if (solved_q != '1) begin
              solved_d = solved_q + 1'b1;
            end
          end
        end else begin
          free_d = free_q + 1'b1;
        end
        if (last_proc) begin
          state_d = S_POP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_POP: begin
        idx_d   = '0;
        state_d = S_DONE;
        if (fill_q != '0) begin
          head_d = qptr_next(head_q);
          aid_d  = rd_q.id;
          cur_d  = rd_q;
          if (CMP_W'(free_q) >= CMP_W'(rd_q.procs)) begin
            assigned_d = 1'b1;
            left_d     = rd_q.procs;
            fill_d     = fill_q - 1'b1;
            state_d    = S_ASSIGN;
          end else begin
            // pop and push cancel: fill stays
            requeued_d = 1'b1;
            mem_we     = 1'b1;
            mem_wdata  = rd_q;
            tail_d     = qptr_next(tail_q);
          end
        end
      end
      S_ASSIGN: begin
        if (!pbusy_q[idx_q] && (left_q != '0)) begin
          pbusy_d[idx_q]  = 1'b1;
          ptotal_d[idx_q] = cur_q.steps;
          pstep_d[idx_q]  = '0;
          left_d          = left_q - 1'b1;
        end
        if (last_proc) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      fill_q     <= '0;
      pbusy_q    <= '0;
      idx_q      <= '0;
      free_q     <= '0;
      left_q     <= '0;
      solved_q   <= '0;
      comp_q     <= '0;
      assigned_q <= 1'b0;
      requeued_q <= 1'b0;
      dropped_q  <= 1'b0;
      aid_q      <= '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        pstep_q[i]  <= '0;
        ptotal_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      fill_q     <= fill_d;
      pbusy_q    <= pbusy_d;
      idx_q      <= idx_d;
      free_q     <= free_d;
      left_q     <= left_d;
      solved_q   <= solved_d;
      comp_q     <= comp_d;
      assigned_q <= assigned_d;
      requeued_q <= requeued_d;
      dropped_q  <= dropped_d;
      aid_q      <= aid_d;
      pstep_q    <= pstep_d;
      ptotal_q   <= ptotal_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    cur_q <= cur_d;
  end

  // queue memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[head_q];
  end

  // result
  always_comb begin
    logic [FSAT_W-1:0] fsat;
    fsat                 = FSAT_W'(free_q);
    res_o                = '0;
    res_o.assigned       = assigned_q;
    res_o.assigned_id    = aid_q;
    res_o.requeued       = requeued_q;
    res_o.dropped        = dropped_q;
    res_o.queue_count    = QCOUNT_W'(fill_q);
    res_o.total_solved   = solved_q;
    res_o.free_count     = (fsat > FSAT_W'(2 ** FREE_W - 1)) ? '1 : FREE_W'(fsat);
    for (int i = 0; i < MASK_N; i++) begin
      res_o.busy_mask[i]      = pbusy_q[i];
      res_o.completed_mask[i] = comp_q[i];
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  `FGTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !res_valid_o, "tick did not start")
  `FGTS_ASSERT_NEXT(a_strobe_single, res_valid_o, !res_valid_o && !busy, "result strobe too long")
  `FGTS_ASSERT(a_fill_bound, fill_q <= QCNT_W'(QUEUE_DEPTH), "queue fill beyond depth")
  `FGTS_ASSERT(a_pop_outcome, !(res_valid_o && res_o.assigned && res_o.requeued),
    "head task both started and requeued")

endmodule

[tb/fgts_sched_checker.sv]
// Scoreboard for the gang task scheduler: predicts every tick and compares each result.
`timescale 1ns / 1ps
module fgts_sched_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  fgts_pkg::task_in_t   task_i,
  input  logic                 res_valid_i,
  input  fgts_pkg::sched_res_t res_i,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o,
  output int                   started_o,
  output int                   requeued_o,
  output int                   dropped_o
);
  import fgts_pkg::*;

  localparam int MAX_SHOWN = 10;

  qentry_t             task_fifo[$];
  logic                cpu_busy[NUM_PROCS];
  logic [STEP_W-1:0]   cpu_step[NUM_PROCS];
  logic [STEP_W-1:0]   cpu_len[NUM_PROCS];
  logic [SOLVED_W-1:0] solved_cnt;
  sched_res_t          tick_results[$];
  sched_res_t          predicted;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    checked_o    = 0;
    started_o    = 0;
    requeued_o   = 0;
    dropped_o    = 0;
  end

  // One scheduler tick: arrival, processor stepping, then head pop.
  task automatic schedule_tick(input task_in_t t, output sched_res_t r);
    qentry_t e;
    int      idle;
    int      left;
    r    = '0;
    idle = 0;
    if (t.task_valid) begin
      if (task_fifo.size() >= QUEUE_DEPTH) begin
        r.dropped = 1'b1;
      end else begin
        e.id    = t.task_id;
        e.steps = t.task_steps;
        e.procs = t.task_procs;
        task_fifo.push_back(e);
      end
    end
    for (int i = 0; i < NUM_PROCS; i++) begin
      if (cpu_busy[i]) begin
        if (cpu_step[i] < cpu_len[i]) cpu_step[i] = cpu_step[i] + 1'b1;
        if (cpu_step[i] == cpu_len[i]) begin
          cpu_busy[i] = 1'b0;
          cpu_step[i] = '0;
          cpu_len[i]  = '0;
          if (solved_cnt != '1) solved_cnt = solved_cnt + 1'b1;
          if (i < MASK_W) r.completed_mask[i] = 1'b1;
        end
      end
    end
    for (int i = 0; i < NUM_PROCS; i++)
      if (!cpu_busy[i]) idle++;
    if (task_fifo.size() > 0) begin
      e = task_fifo.pop_front();
      r.assigned_id = e.id;
      if (idle >= int'(e.procs)) begin
        r.assigned = 1'b1;
        left = int'(e.procs);
        for (int i = 0; i < NUM_PROCS; i++) begin
          if (left > 0 && !cpu_busy[i]) begin
            cpu_busy[i] = 1'b1;
            cpu_len[i]  = e.steps;
            cpu_step[i] = '0;
            left--;
          end
        end
      end else begin
        r.requeued = 1'b1;
        task_fifo.push_back(e);
      end
    end
    for (int i = 0; i < NUM_PROCS && i < MASK_W; i++)
      if (cpu_busy[i]) r.busy_mask[i] = 1'b1;
    r.queue_count  = QCOUNT_W'(task_fifo.size());
    r.free_count   = (idle > 15) ? 4'd15 : FREE_W'(idle);
    r.total_solved = solved_cnt;
  endtask

  function automatic string fmt_result(input sched_res_t r);
    return $sformatf({"asg=%0b id=%0d rq=%0b drop=%0b qcnt=%0d busy=%h done=%h ",
                      "free=%0d solved=%0d"},
                     r.assigned, r.assigned_id, r.requeued, r.dropped, r.queue_count,
                     r.busy_mask, r.completed_mask, r.free_count, r.total_solved);
  endfunction

  task automatic check_result(input sched_res_t got);
    sched_res_t want;
    string      diff;
    if (tick_results.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= MAX_SHOWN)
        $display("ERROR: %0t result with nothing outstanding: %s", $realtime, fmt_result(got));
      return;
    end
    want = tick_results.pop_front();
    checked_o++;
    diff = "";
    if (got.assigned       !== want.assigned)       diff = {diff, " assigned"};
    if (got.assigned_id    !== want.assigned_id)    diff = {diff, " assigned_id"};
    if (got.requeued       !== want.requeued)       diff = {diff, " requeued"};
    if (got.dropped        !== want.dropped)        diff = {diff, " dropped"};
    if (got.queue_count    !== want.queue_count)    diff = {diff, " queue_count"};
    if (got.busy_mask      !== want.busy_mask)      diff = {diff, " busy_mask"};
    if (got.completed_mask !== want.completed_mask) diff = {diff, " completed_mask"};
    if (got.free_count     !== want.free_count)     diff = {diff, " free_count"};
    if (got.total_solved   !== want.total_solved)   diff = {diff, " total_solved"};
    if (diff != "") begin
      fail_count_o++;
      if (fail_count_o <= MAX_SHOWN) begin
        $display("ERROR: %0t tick %0d differs in%s", $realtime, checked_o, diff);
        $display("  expected %s", fmt_result(want));
        $display("  actual   %s", fmt_result(got));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_fifo.delete();
      tick_results.delete();
      for (int i = 0; i < NUM_PROCS; i++) begin
        cpu_busy[i] = 1'b0;
        cpu_step[i] = '0;
        cpu_len[i]  = '0;
      end
      solved_cnt = '0;
      pending_o  = 0;
    end else begin
      // result first: a transfer in and a result never share an edge anyway
      if (res_valid_i) check_result(res_i);
      if (start_i && !busy_i) begin
        schedule_tick(task_i, predicted);
        tick_results.push_back(predicted);
        if (predicted.assigned) started_o++;
        if (predicted.requeued) requeued_o++;
        if (predicted.dropped) dropped_o++;
      end
      pending_o = tick_results.size();
    end
  end

endmodule

[tb/fifo_gang_task_scheduler_core_test.sv]
// Stimulus and verdict for the gang task scheduler core; checking lives in fgts_sched_checker.
`timescale 1ns / 1ps
module fifo_gang_task_scheduler_core_test;
  import fgts_pkg::*;

  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_TICKS    = 75;
  localparam int FLOOD_TICKS    = 140;
  localparam int LONG_TRIES     = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES    = 40;
  localparam logic [ID_W-1:0] LONG_ID = 10'h3A5;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  task_in_t   task_i;
  logic       res_valid_o;
  sched_res_t res_o;

  int   fail_count;
  int   pending;
  int   n_checked;
  int   n_started;
  int   n_requeued;
  int   n_dropped;
  int   idle_cycles = 0;
  int   gap_max = 4;
  int   sent = 0;
  logic long_task_running = 1'b0;

  fifo_gang_task_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .task_i      (task_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  fgts_sched_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .task_i       (task_i),
    .res_valid_i  (res_valid_o),
    .res_i        (res_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (n_checked),
    .started_o    (n_started),
    .requeued_o   (n_requeued),
    .dropped_o    (n_dropped)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic task_in_t task_of(input logic [ID_W-1:0] id,
                                       input logic [STEP_W-1:0] steps,
                                       input logic [PROCS_W-1:0] procs);
    task_in_t t;
    t.task_valid = 1'b1;
    t.task_id    = id;
    t.task_steps = steps;
    t.task_procs = procs;
    return t;
  endfunction

  // Mostly small gangs and short runs so the processors keep turning over.
  function automatic task_in_t rand_task(input int valid_pct);
    task_in_t t;
    int       roll;
    t.task_valid = ($urandom_range(99, 0) < valid_pct);
    t.task_id    = ID_W'($urandom);
    roll = $urandom_range(999, 0);
    if (roll < 30)       t.task_procs = '0;
    else if (roll < 35)  t.task_procs = PROCS_W'($urandom_range(15, NUM_PROCS + 1));
    else if (roll < 700) t.task_procs = PROCS_W'($urandom_range(3, 1));
    else                 t.task_procs = PROCS_W'($urandom_range(NUM_PROCS, 1));
    roll = $urandom_range(99, 0);
    if (roll < 70)       t.task_steps = STEP_W'($urandom_range(7, 0));
    else if (roll < 95)  t.task_steps = STEP_W'($urandom_range(63, 8));
    else                 t.task_steps = STEP_W'($urandom_range(400, 64));
    return t;
  endfunction

  // the gap counts from the first cycle the core could take the transfer
  task automatic send_tick(input task_in_t t);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    start  <= 1'b1;
    task_i <= t;
    @(posedge clk_i);
    sent++;
    @(negedge clk_i);
    start  <= 1'b0;
    task_i <= task_in_t'($urandom);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // a full gang with the longest run: once it holds every processor, nothing else fits
  always @(posedge clk_i)
    if (res_valid_o && res_o.assigned && res_o.assigned_id == LONG_ID && (&res_o.busy_mask))
      long_task_running <= 1'b1;

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int tries;
    rst_ni = 1'b0;
    start  = 1'b0;
    task_i = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: arrival into empty queue, zero steps, zero procs, full gang, oversize gangs
    send_tick(task_of(10'd0, 12'd1, 4'd1));
    send_tick(task_of(10'h3FF, 12'd0, 4'd1));
    send_tick(task_of(10'd5, 12'd9, 4'd0));
    send_tick(task_of(10'h2AA, 12'd3, PROCS_W'(NUM_PROCS)));
    send_tick(task_of(10'h155, 12'd2, 4'hF));
    send_tick(task_of(10'h0F0, 12'd6, 4'd5));
    send_tick(task_of(10'h30F, 12'd4, 4'd4));
    send_tick(task_of(10'h011, 12'd2, PROCS_W'(NUM_PROCS + 1)));
    send_tick(task_of(10'h0C3, 12'd0, 4'd0));
    send_tick(task_of(10'h23C, 12'd5, 4'd2));
    repeat (8) send_tick(rand_task(0));
    send_tick(task_of(10'h100, 12'd1, PROCS_W'(NUM_PROCS)));
    send_tick(task_of(10'h200, 12'd1, 4'd3));
    repeat (3) send_tick(rand_task(0));
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gap_max = (phase % 3 == 1) ? 0 : 4;
      for (int k = 0; k < PHASE_TICKS; k++)
        send_tick(rand_task((k < PHASE_TICKS - 15) ? 40 : 0));
      if (phase == RANDOM_PHASES / 2) wait_drained();
    end

    // overflow: pin every processor with a long gang, then flood full-gang arrivals
    gap_max = 4;
    send_tick(task_of(LONG_ID, '1, PROCS_W'(NUM_PROCS)));
    tries = 0;
    while (!long_task_running && tries < LONG_TRIES) begin
      send_tick(rand_task(0));
      tries++;
    end
    gap_max = 0;
    repeat (FLOOD_TICKS)
      send_tick(task_of(ID_W'($urandom), STEP_W'($urandom), PROCS_W'(NUM_PROCS)));

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Ran %0d ticks, %0d results compared, %0d errors: %0d gang starts, %0d requeues,",
             sent, n_checked, fail_count, n_started, n_requeued);
    $display("  %0d drops; random and back-to-back spacing, a mid-run drain, overflow at the end",
             n_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/fgts_pkg.sv
hdl/fifo_gang_task_scheduler_core.sv
tb/fgts_sched_checker.sv
tb/fifo_gang_task_scheduler_core_test.sv
